@@ hdl/fcbg_pkg.sv @@
// Shared types, codes and constants of the floppy card bus glue.
package fcbg_pkg;

  localparam int MOTOR_COUNT_BITS = 24;
  localparam int CFG_W = 24;

  typedef enum logic [2:0] {
    OP_CRU_RD  = 3'd0,
    OP_CRU_WR  = 3'd1,
    OP_MEM_RD  = 3'd2,
    OP_MEM_WR  = 3'd3,
    OP_FDC_EVT = 3'd4,
    OP_TICK    = 3'd5
  } fcbg_op_t;

  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_RAM  = 3'd2,
    TGT_RTC  = 3'd3,
    TGT_FDC  = 3'd4
  } fcbg_target_t;

  // CRU bit numbers
  localparam logic [12:0] CRU_STATUS  = 13'd0;
  localparam logic [12:0] CRU_MOTOR   = 13'd1;
  localparam logic [12:0] CRU_HOLD    = 13'd2;
  localparam logic [12:0] CRU_DSEL0   = 13'd4;
  localparam logic [12:0] CRU_DSEL1   = 13'd5;
  localparam logic [12:0] CRU_DSEL2   = 13'd6;
  localparam logic [12:0] CRU_SIDE    = 13'd7;
  localparam logic [12:0] CRU_DENSITY = 13'd10;
  localparam logic [12:0] CRU_ROM_A13 = 13'd11;
  localparam logic [12:0] CRU_RAM_A10 = 13'd13;
  localparam logic [12:0] CRU_RTC_EN  = 13'd14;
  localparam logic [12:0] CRU_ROM_A14 = 13'd15;

  // controller line events
  localparam logic [7:0] EVT_IRQ_CLR = 8'd0;
  localparam logic [7:0] EVT_IRQ_SET = 8'd1;
  localparam logic [7:0] EVT_DRQ_CLR = 8'd2;
  localparam logic [7:0] EVT_DRQ_SET = 8'd3;

  localparam logic [7:0] CRU_ID_BYTE = 8'h50;
  localparam logic [1:0] DRIVE_NONE  = 2'd3;

  // card space map
  localparam logic [12:0] RAM_START = 13'h1c00;
  localparam logic [12:0] HI_START  = 13'h1fe0;
  localparam logic [12:0] FDC_START = 13'h1ff0;
  localparam logic [12:0] FDC_WR    = 13'h1ff8;

  localparam logic [32:0] COUNT_MAX = (33'd1 << MOTOR_COUNT_BITS) - 33'd1;

  typedef logic [MOTOR_COUNT_BITS-1:0] fcbg_count_t;

  typedef struct packed {
    fcbg_op_t    opcode;
    logic [12:0] offset;
    logic [7:0]  data;
  } fcbg_in_t;

  typedef struct packed {
    logic [7:0]   read_data;
    fcbg_target_t target;
    logic [14:0]  target_address;
    logic         target_write;
    logic [1:0]   drive_number;
    logic         drive_changed;
    logic         disk_side;
    logic         double_density;
    logic         cpu_halt;
    logic         card_interrupt;
  } fcbg_out_t;

  // paging state seen by the memory decoder
  typedef struct packed {
    logic       rtc_override;
    logic [1:0] rom_page;
    logic       ram_page;
  } fcbg_map_t;

  typedef struct packed {
    fcbg_target_t target;
    logic [14:0]  address;
    logic         write;
  } fcbg_dec_t;

  function automatic fcbg_count_t sat_ticks(input logic [CFG_W-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    if (ext > COUNT_MAX) begin
      ext = COUNT_MAX;
    end
    return ext[MOTOR_COUNT_BITS-1:0];
  endfunction

  localparam fcbg_count_t MOTOR_TICKS_RST = sat_ticks(CFG_W'(4230));

endpackage

@@ hdl/fcbg_mem_decode.sv @@
// Memory map decoder: card offset to rom, ram, rtc or controller register.
module fcbg_mem_decode import fcbg_pkg::*; (
  input  fcbg_op_t    opcode,
  input  logic [12:0] offset,
  input  fcbg_map_t   map,
  output fcbg_dec_t   dec
);

  logic is_mem;
  logic wr;

  assign is_mem = (opcode == OP_MEM_RD) || (opcode == OP_MEM_WR);
  assign wr     = (opcode == OP_MEM_WR);

  always_comb begin
    dec = '{target: TGT_NONE, address: 15'd0, write: 1'b0};
    if (is_mem) begin
      if (offset < RAM_START) begin
        if (!wr) begin
          dec.target  = TGT_ROM;
          dec.address = {map.rom_page[1], map.rom_page[0], offset};
        end
      end else if (offset < HI_START) begin
        dec.target  = TGT_RAM;
        dec.address = {4'd0, map.ram_page, offset[9:0]};
      end else if (map.rtc_override) begin
        if (!offset[0]) begin
          dec.target  = TGT_RTC;
          dec.address = {11'd0, offset[4:1]};
        end
      end else if (offset < FDC_START) begin
        dec.target  = TGT_RAM;
        dec.address = {4'd0, map.ram_page, offset[9:0]};
      end else if (!wr) begin
        if (offset < FDC_WR && !offset[0]) begin
          dec.target  = TGT_FDC;
          dec.address = {13'd0, offset[2:1]};
        end
      end else begin
        if (offset >= FDC_WR && !offset[0]) begin
          dec.target  = TGT_FDC;
          dec.address = {13'd0, offset[2:1]};
        end
      end
      dec.write = wr && (dec.target != TGT_NONE);
    end
  end

endmodule

@@ hdl/fcbg_ctrl.sv @@
// Card state: CRU bits, drive select, motor countdown, controller flags.
module fcbg_ctrl import fcbg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  fcbg_in_t         req,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_value,
  output fcbg_out_t        result
);

  fcbg_count_t motor_ticks_r, motor_ticks_nxt;
  fcbg_count_t motor_cnt_r, motor_cnt_nxt;
  logic [2:0]  dsel_r, dsel_nxt;
  logic [1:0]  drive_r, drive_nxt;
  logic        side_r, side_nxt;
  logic        mfm_r, mfm_nxt;
  logic        strobe_r, strobe_nxt;
  logic        motor_r, motor_nxt;
  logic        hold_r, hold_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [1:0]  rom_page_r, rom_page_nxt;
  logic        ram_page_r, ram_page_nxt;
  logic        rtc_r, rtc_nxt;

  fcbg_map_t   map;
  fcbg_dec_t   dec;
  logic        d;
  logic [1:0]  drv;
  logic [7:0]  rd;

  assign map = '{rtc_override: rtc_r, rom_page: rom_page_r, ram_page: ram_page_r};

  fcbg_mem_decode u_dec (
    .opcode (req.opcode),
    .offset (req.offset),
    .map    (map),
    .dec    (dec)
  );

  assign d   = req.data[0];
  assign drv = req.offset[1:0];

  always_comb begin
    motor_ticks_nxt = cfg_we ? sat_ticks(cfg_value) : motor_ticks_r;
    motor_cnt_nxt   = motor_cnt_r;
    dsel_nxt        = dsel_r;
    drive_nxt       = drive_r;
    side_nxt        = side_r;
    mfm_nxt         = mfm_r;
    strobe_nxt      = strobe_r;
    motor_nxt       = motor_r;
    hold_nxt        = hold_r;
    flags_nxt       = flags_r;
    rom_page_nxt    = rom_page_r;
    ram_page_nxt    = ram_page_r;
    rtc_nxt         = rtc_r;
    rd              = 8'd0;

    case (req.opcode)
      OP_CRU_RD: begin
        if (req.offset == CRU_STATUS) begin
          rd = CRU_ID_BYTE | (motor_r ? {4'd0, dsel_r, 1'b0} : 8'd0);
        end
      end
      OP_CRU_WR: begin
        case (req.offset)
          CRU_MOTOR: begin
            // rising edge of the strobe retriggers the countdown
            if (d && !strobe_r) begin
              motor_nxt     = 1'b1;
              motor_cnt_nxt = motor_ticks_r;
            end
            strobe_nxt = d;
          end
          CRU_HOLD: hold_nxt = d;
          CRU_DSEL0, CRU_DSEL1, CRU_DSEL2: begin
            if (d) begin
              dsel_nxt  = dsel_r | (3'b001 << drv);
              drive_nxt = drv;
            end else begin
              dsel_nxt = dsel_r & ~(3'b001 << drv);
              if (drv == drive_r) begin
                drive_nxt = DRIVE_NONE;
              end
            end
          end
          CRU_SIDE:    side_nxt = d;
          CRU_DENSITY: mfm_nxt = !d;
          CRU_ROM_A13: rom_page_nxt[0] = d;
          CRU_RAM_A10: ram_page_nxt = d;
          CRU_RTC_EN:  rtc_nxt = d;
          CRU_ROM_A14: rom_page_nxt[1] = d;
          default: ;
        endcase
      end
      OP_FDC_EVT: begin
        case (req.data)
          EVT_IRQ_CLR: flags_nxt[0] = 1'b0;
          EVT_IRQ_SET: flags_nxt[0] = 1'b1;
          EVT_DRQ_CLR: flags_nxt[1] = 1'b0;
          EVT_DRQ_SET: flags_nxt[1] = 1'b1;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (motor_r) begin
          if (motor_cnt_r <= fcbg_count_t'(1)) begin
            motor_cnt_nxt = '0;
            motor_nxt     = 1'b0;
          end else begin
            motor_cnt_nxt = motor_cnt_r - fcbg_count_t'(1);
          end
        end
      end
      default: ;
    endcase

    result.read_data      = rd;
    result.target         = dec.target;
    result.target_address = dec.address;
    result.target_write   = dec.write;
    result.drive_number   = drive_nxt;
    // pulse only on a select; a deselect drops the drive without a pulse
    result.drive_changed  = d && (drive_nxt != drive_r);
    result.disk_side      = side_nxt;
    result.double_density = mfm_nxt;
    result.cpu_halt       = hold_nxt && motor_nxt && (flags_nxt == 2'b00);
    result.card_interrupt = flags_nxt[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_ticks_r <= MOTOR_TICKS_RST;
    end else begin
      motor_ticks_r <= motor_ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_cnt_r <= '0;
      dsel_r      <= 3'd0;
      drive_r     <= DRIVE_NONE;
      side_r      <= 1'b0;
      mfm_r       <= 1'b1;
      strobe_r    <= 1'b0;
      motor_r     <= 1'b0;
      hold_r      <= 1'b0;
      flags_r     <= 2'd0;
      rom_page_r  <= 2'd0;
      ram_page_r  <= 1'b0;
      rtc_r       <= 1'b0;
    end else if (advance) begin
      motor_cnt_r <= motor_cnt_nxt;
      dsel_r      <= dsel_nxt;
      drive_r     <= drive_nxt;
      side_r      <= side_nxt;
      mfm_r       <= mfm_nxt;
      strobe_r    <= strobe_nxt;
      motor_r     <= motor_nxt;
      hold_r      <= hold_nxt;
      flags_r     <= flags_nxt;
      rom_page_r  <= rom_page_nxt;
      ram_page_r  <= ram_page_nxt;
      rtc_r       <= rtc_nxt;
    end
  end

endmodule

@@ hdl/floppy_card_bus_glue_top.sv @@
// Floppy card bus glue: input register, state update, result register.
// The result register is loaded as the request leaves the request register.
// Throughput: one request per cycle while results are taken; requests drain
// into the result register whenever it is empty or being taken.
// Reset: synchronous, active low; clears both stages and all card state and
// restores the motor run time of 4230 ticks.
module floppy_card_bus_glue_top import fcbg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  fcbg_in_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output fcbg_out_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  logic      in_valid_r, in_valid_nxt;
  fcbg_in_t  in_r;
  logic      out_valid_r, out_valid_nxt;
  fcbg_out_t out_r;
  fcbg_out_t result;
  logic      advance;

  assign advance       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready      = !in_valid_r || advance;
  assign in_valid_nxt  = (in_valid && in_ready) || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_ready);
  assign cfg_ready     = 1'b1;

  fcbg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .req       (in_r),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold each stage's payload until it moves on
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ sim/floppy_card_bus_glue_top_tb.sv @@
// Self-checking testbench of the floppy card bus glue: directed and random bus traffic.
`timescale 1ns / 100ps

module floppy_card_bus_glue_top_tb;
  import fcbg_pkg::*;

  localparam logic [2:0]  OP_SPARE_A    = 3'd6;
  localparam logic [2:0]  OP_SPARE_B    = 3'd7;
  localparam logic [7:0]  EVT_BOGUS     = 8'hff;
  localparam logic [12:0] CRU_TOP_BIT   = 13'h1fff;
  localparam logic [12:0] CRU_SPARE     = 13'd3;
  localparam logic [14:0] RAM_PAGE_BASE = 15'h0400;
  localparam int          QUIET_CYCLES  = 4;
  localparam int          STALL_LIMIT   = 2000;
  localparam int          PHASE_ITEMS   = 290;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  fcbg_in_t         in_data;
  logic             out_valid;
  logic             out_ready;
  fcbg_out_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  // card state as the bus sees it
  logic [2:0]  dsel;
  logic [1:0]  cur_drive;
  logic        side;
  logic        mfm;
  logic        last_strobe;
  logic        motor_run;
  fcbg_count_t countdown;
  fcbg_count_t on_ticks;
  logic        hold;
  logic        irq;
  logic        drq;
  logic [1:0]  rom_page;
  logic        ram_page;
  logic        rtc_en;

  fcbg_out_t predicted_replies[$];
  int        mismatches;
  int        idle_cycles;
  logic      no_idle;

  logic [12:0] cru_bits [11] = '{CRU_MOTOR, CRU_HOLD, CRU_DSEL0, CRU_DSEL1, CRU_DSEL2,
                                 CRU_SIDE, CRU_DENSITY, CRU_ROM_A13, CRU_RAM_A10,
                                 CRU_RTC_EN, CRU_ROM_A14};

  floppy_card_bus_glue_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_card_state();
    dsel        = '0;
    cur_drive   = DRIVE_NONE;
    side        = 1'b0;
    mfm         = 1'b1;
    last_strobe = 1'b0;
    motor_run   = 1'b0;
    countdown   = '0;
    on_ticks    = MOTOR_TICKS_RST;
    hold        = 1'b0;
    irq         = 1'b0;
    drq         = 1'b0;
    rom_page    = '0;
    ram_page    = 1'b0;
    rtc_en      = 1'b0;
  endfunction

  // Advance the card state by one request and return the reply it should give.
  function automatic fcbg_out_t card_response(input fcbg_in_t req);
    fcbg_out_t  r;
    logic [1:0] prev_drive;
    logic [1:0] drv;
    logic       bitv;
    logic       is_wr;
    r          = '0;
    r.target   = TGT_NONE;
    bitv       = req.data[0];
    is_wr      = (req.opcode == OP_MEM_WR);
    prev_drive = cur_drive;
    case (req.opcode)
      OP_CRU_RD: begin
        if (req.offset == CRU_STATUS) begin
          r.read_data = motor_run ? (CRU_ID_BYTE | {4'b0, dsel, 1'b0}) : CRU_ID_BYTE;
        end
      end
      OP_CRU_WR: begin
        case (req.offset)
          CRU_MOTOR: begin
            if (bitv && !last_strobe) begin
              motor_run = 1'b1;
              countdown = on_ticks;
            end
            last_strobe = bitv;
          end
          CRU_HOLD: hold = bitv;
          CRU_DSEL0, CRU_DSEL1, CRU_DSEL2: begin
            drv = 2'(req.offset - CRU_DSEL0);
            dsel[drv] = bitv;
            if (bitv) begin
              cur_drive = drv;
            end else if (drv == cur_drive) begin
              cur_drive = DRIVE_NONE;
            end
          end
          CRU_SIDE:    side = bitv;
          CRU_DENSITY: mfm = !bitv;
          CRU_ROM_A13: rom_page[0] = bitv;
          CRU_RAM_A10: ram_page = bitv;
          CRU_RTC_EN:  rtc_en = bitv;
          CRU_ROM_A14: rom_page[1] = bitv;
          default: ;
        endcase
        r.drive_changed = bitv && (cur_drive != prev_drive);
      end
      OP_MEM_RD, OP_MEM_WR: begin
        if (req.offset < RAM_START) begin
          // rom is read only
          if (!is_wr) begin
            r.target         = TGT_ROM;
            r.target_address = {rom_page, 13'b0} | 15'(req.offset);
          end
        end else if (req.offset < HI_START || (!rtc_en && req.offset < FDC_START)) begin
          r.target         = TGT_RAM;
          r.target_address = (ram_page ? RAM_PAGE_BASE : 15'd0) + 15'(req.offset - RAM_START);
        end else if (rtc_en) begin
          if (!req.offset[0]) begin
            r.target         = TGT_RTC;
            r.target_address = 15'((req.offset - HI_START) >> 1);
          end
        end else if (!req.offset[0] && (is_wr == (req.offset >= FDC_WR))) begin
          // controller reads in the lower half, writes in the upper half
          r.target         = TGT_FDC;
          r.target_address = 15'((req.offset - (is_wr ? FDC_WR : FDC_START)) >> 1);
        end
        r.target_write = is_wr && (r.target != TGT_NONE);
      end
      OP_FDC_EVT: begin
        case (req.data)
          EVT_IRQ_CLR: irq = 1'b0;
          EVT_IRQ_SET: irq = 1'b1;
          EVT_DRQ_CLR: drq = 1'b0;
          EVT_DRQ_SET: drq = 1'b1;
          default: ;
        endcase
      end
      OP_TICK: begin
        if (motor_run) begin
          if (countdown <= 1) begin
            countdown = '0;
            motor_run = 1'b0;
          end else begin
            countdown = countdown - 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.drive_number   = cur_drive;
    r.disk_side      = side;
    r.double_density = mfm;
    r.cpu_halt       = hold && motor_run && !irq && !drq;
    r.card_interrupt = irq;
    return r;
  endfunction

  function automatic fcbg_in_t mk(input logic [2:0] op, input logic [12:0] off,
                                  input logic [7:0] dat);
    fcbg_in_t r;
    r.opcode = fcbg_op_t'(op);
    r.offset = off;
    r.data   = dat;
    return r;
  endfunction

  // Mostly meaningful accesses with random content, some noise on top.
  function automatic fcbg_in_t random_request();
    int          pick;
    logic [12:0] off;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 2))
      0:       off = 13'($urandom_range(0, 8191));
      1:       off = RAM_START + 13'($urandom_range(0, 1023));
      default: off = HI_START + 13'($urandom_range(0, 31));
    endcase
    if (pick < 22) begin
      return mk(OP_CRU_WR, cru_bits[$urandom_range(0, 10)], 8'($urandom));
    end else if (pick < 27) begin
      return mk(OP_CRU_WR, 13'($urandom), 8'($urandom));
    end else if (pick < 37) begin
      return mk(OP_CRU_RD, ($urandom_range(0, 3) != 0) ? CRU_STATUS : 13'($urandom),
                8'($urandom));
    end else if (pick < 62) begin
      return mk($urandom_range(0, 1) ? OP_MEM_WR : OP_MEM_RD, off, 8'($urandom));
    end else if (pick < 72) begin
      return mk(OP_FDC_EVT, 13'($urandom),
                ($urandom_range(0, 7) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom));
    end else if (pick < 97) begin
      return mk(OP_TICK, 13'($urandom), 8'($urandom));
    end
    return mk($urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A, 13'($urandom), 8'($urandom));
  endfunction

  // Hold the request until taken; valid only drops when a gap follows.
  task automatic send_request(input fcbg_in_t req);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predicted_replies.push_back(card_response(req));
  endtask

  task automatic wait_bus_quiet();
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_motor_ticks(input logic [CFG_W-1:0] val);
    wait_bus_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    on_ticks = fcbg_count_t'(val);
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic test_drive_select();
    send_request(mk(OP_CRU_RD, CRU_STATUS, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_DSEL0, 8'h01));
    // reselect of the current drive: no pulse
    send_request(mk(OP_CRU_WR, CRU_DSEL0, 8'hff));
    send_request(mk(OP_CRU_WR, CRU_DSEL2, 8'h01));
    send_request(mk(OP_CRU_WR, CRU_DSEL0, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_DSEL2, 8'hfe));
    send_request(mk(OP_CRU_WR, CRU_DSEL1, 8'h01));
  endtask

  task automatic test_motor_and_lines();
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h01));
    send_request(mk(OP_CRU_RD, CRU_STATUS, 8'h00));
    send_request(mk(OP_CRU_RD, CRU_TOP_BIT, 8'hff));
    send_request(mk(OP_CRU_WR, CRU_HOLD, 8'h01));
    send_request(mk(OP_FDC_EVT, 13'h0000, EVT_IRQ_SET));
    send_request(mk(OP_FDC_EVT, 13'h1fff, EVT_DRQ_SET));
    send_request(mk(OP_FDC_EVT, 13'h0000, EVT_IRQ_CLR));
    send_request(mk(OP_FDC_EVT, 13'h0000, EVT_BOGUS));
    send_request(mk(OP_FDC_EVT, 13'h0000, EVT_DRQ_CLR));
    send_request(mk(OP_TICK, 13'h1fff, 8'hff));
  endtask

  task automatic test_card_controls();
    send_request(mk(OP_CRU_WR, CRU_SIDE, 8'h01));
    send_request(mk(OP_CRU_WR, CRU_DENSITY, 8'h01));
    send_request(mk(OP_CRU_WR, CRU_ROM_A13, 8'h01));
    send_request(mk(OP_CRU_WR, CRU_ROM_A14, 8'h01));
    send_request(mk(OP_CRU_WR, CRU_RAM_A10, 8'h01));
    send_request(mk(OP_CRU_WR, CRU_SPARE, 8'hff));
    send_request(mk(OP_CRU_WR, CRU_TOP_BIT, 8'hff));
  endtask

  task automatic test_memory_map();
    send_request(mk(OP_MEM_RD, 13'h0000, 8'h00));
    send_request(mk(OP_MEM_RD, RAM_START - 13'd1, 8'h00));
    send_request(mk(OP_MEM_WR, 13'h0000, 8'hff));
    send_request(mk(OP_MEM_WR, RAM_START, 8'h00));
    send_request(mk(OP_MEM_RD, FDC_START - 13'd1, 8'h00));
    send_request(mk(OP_MEM_RD, FDC_START + 13'd6, 8'h00));
    send_request(mk(OP_MEM_RD, FDC_START + 13'd7, 8'h00));
    send_request(mk(OP_MEM_RD, FDC_WR, 8'h00));
    send_request(mk(OP_MEM_WR, FDC_WR + 13'd6, 8'h00));
    send_request(mk(OP_MEM_WR, FDC_START, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_RTC_EN, 8'h01));
    send_request(mk(OP_MEM_RD, HI_START, 8'h00));
    send_request(mk(OP_MEM_WR, 13'h1ffe, 8'h00));
    send_request(mk(OP_MEM_WR, 13'h1fff, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_RTC_EN, 8'h00));
  endtask

  task automatic test_unused_opcodes();
    send_request(mk(OP_SPARE_A, 13'h0001, 8'h01));
    send_request(mk(OP_SPARE_B, 13'h1fff, 8'hff));
  endtask

  task automatic test_motor_countdown();
    // zero count: the first tick turns the motor off
    set_motor_ticks('0);
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h01));
    send_request(mk(OP_TICK, 13'h0000, 8'h00));
    set_motor_ticks(CFG_W'(3));
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h01));
    send_request(mk(OP_TICK, 13'h0000, 8'h00));
    send_request(mk(OP_TICK, 13'h0000, 8'h00));
    // retrigger while running reloads the count
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h00));
    send_request(mk(OP_CRU_WR, CRU_MOTOR, 8'h01));
    repeat (3) send_request(mk(OP_TICK, 13'h0000, 8'h00));
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] phase_ticks [5];
    phase_ticks = '{'1, CFG_W'(1), CFG_W'($urandom_range(2, 12)), '0, CFG_W'(4230)};
    foreach (phase_ticks[p]) begin
      set_motor_ticks(phase_ticks[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        no_idle = ((i / 60) % 3 == 2);
        send_request(random_request());
      end
      no_idle = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    fcbg_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: reply expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("read_data", want.read_data, out_data.read_data);
        check_field("target", want.target, out_data.target);
        check_field("target_address", want.target_address, out_data.target_address);
        check_field("target_write", want.target_write, out_data.target_write);
        check_field("drive_number", want.drive_number, out_data.drive_number);
        check_field("drive_changed", want.drive_changed, out_data.drive_changed);
        check_field("disk_side", want.disk_side, out_data.disk_side);
        check_field("double_density", want.double_density, out_data.double_density);
        check_field("cpu_halt", want.cpu_halt, out_data.cpu_halt);
        check_field("card_interrupt", want.card_interrupt, out_data.card_interrupt);
      end
    end
  end

  // Receiver: hold ready low for a random stall before each reply, except in no-idle phases.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    mismatches  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    reset_card_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_drive_select();
    test_motor_and_lines();
    test_card_controls();
    test_memory_map();
    test_unused_opcodes();
    test_motor_countdown();
    test_random_traffic();
    wait_bus_quiet();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ floppy_card_bus_glue_top.f @@
hdl/fcbg_pkg.sv
hdl/fcbg_mem_decode.sv
hdl/fcbg_ctrl.sv
hdl/floppy_card_bus_glue_top.sv
sim/floppy_card_bus_glue_top_tb.sv
